/* rtl/fqd_pkg.sv */
// Shared types and constants for the FIFO queue with delete by handle.
// Holds the request codes, the item structs of both channels and the cell control struct.
// No dependencies; every other file in rtl refers to it by scoped names.
package fqd_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int HANDLE_WIDTH = 32;
  localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);

  typedef logic [HANDLE_WIDTH-1:0] handle_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  typedef enum logic [1:0] {
    REQ_ENQUEUE = 2'd0,
    REQ_DEQUEUE = 2'd1,
    REQ_DELETE  = 2'd2
  } req_t;

  typedef struct packed {
    req_t    req_type;
    handle_t handle;
  } in_t;

  typedef struct packed {
    logic    status;
    handle_t out_handle;
    cnt_t    fill_level;
  } out_t;

  // Per-cell controls computed once per accepted item.
  typedef struct packed {
    logic live;    // cell holds a queued entry
    logic wr;      // cell receives the enqueued handle
    logic del_en;  // a delete with a nonzero handle is in progress
  } cell_ctl_t;

endpackage

/* rtl/fifo_queue_with_delete.sv */
// Top level of the FIFO queue with delete by handle: a row of fqd_cell slots,
// the occupancy counter and the result register. Depends on fqd_pkg and fqd_cell.
//
// Usage:
//   The input channel (in_valid, in_stall, in_item) carries one request per item:
//   enqueue, dequeue of the oldest entry, or delete of the oldest entry equal to
//   a handle. The output channel (out_valid, out_stall, out_item) returns one
//   result item per request: status, the dequeued handle and the fill level.
//   Each request is resolved in the cycle it is accepted: all slots compare
//   against the handle at once, a ripple chain along the row picks the oldest
//   match, and every younger slot shifts one place toward the head.
//   out_valid rises in the cycle after acceptance, and one item per cycle
//   is taken while results drain; the single result register sets that figure.
//   While out_valid is high and out_stall is high, in_stall is high and the
//   result holds. Reset empties the queue and drops any pending result; slot
//   contents are left as they are and are never read past the fill level.
module fifo_queue_with_delete (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  fqd_pkg::in_t in_item,
  output logic         out_valid,
  input  logic         out_stall,
  output fqd_pkg::out_t out_item
);

  localparam int D = fqd_pkg::QUEUE_DEPTH;

  fqd_pkg::cnt_t      occ;
  fqd_pkg::cnt_t      occ_next;
  fqd_pkg::handle_t   data  [D];
  fqd_pkg::cell_ctl_t ctl   [D];
  logic [D:0]         found;
  logic               accept;
  logic               is_enq;
  logic               is_deq;
  logic               is_del;
  logic               enq_ok;
  logic               deq_ok;
  logic               del_ok;
  logic               ok;
  fqd_pkg::out_t      res;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign is_enq = (in_item.req_type == fqd_pkg::REQ_ENQUEUE);
  assign is_deq = (in_item.req_type == fqd_pkg::REQ_DEQUEUE);
  assign is_del = (in_item.req_type == fqd_pkg::REQ_DELETE);

  assign enq_ok = is_enq && (in_item.handle != '0) &&
                  (occ < fqd_pkg::cnt_t'(D));
  assign deq_ok = is_deq && (occ != '0);
  assign del_ok = is_del && (in_item.handle != '0) && found[D];
  assign ok     = enq_ok || deq_ok || del_ok;

  // A dequeue starts the removal chain at the head; a delete starts it at the match.
  assign found[0] = deq_ok;

  for (genvar i = 0; i < D; i++) begin : g_cell
    assign ctl[i].live   = (occ > fqd_pkg::cnt_t'(i));
    assign ctl[i].wr     = enq_ok && (occ == fqd_pkg::cnt_t'(i));
    assign ctl[i].del_en = is_del && (in_item.handle != '0);

    fqd_cell u_cell (
      .clk        (clk),
      .en         (accept),
      .ctl        (ctl[i]),
      .handle     (in_item.handle),
      .right_data ((i == D - 1) ? data[i] : data[(i + 1) % D]),
      .found_in   (found[i]),
      .data       (data[i]),
      .found_out  (found[i+1])
    );
  end

  always_comb begin
    occ_next = occ;
    if (enq_ok) begin
      occ_next = occ + fqd_pkg::cnt_t'(1);
    end else if (deq_ok || del_ok) begin
      occ_next = occ - fqd_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    res.status     = !ok;
    res.out_handle = deq_ok ? data[0] : '0;
    res.fill_level = occ_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        occ       <= occ_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item <= res;
    end
  end

endmodule

/* rtl/fqd_cell.sv */
// One slot of the queue: a handle register, its compare against the request handle,
// and its link in the oldest-match chain. Depends on fqd_pkg.
module fqd_cell (
  input  logic               clk,
  input  logic               en,
  input  fqd_pkg::cell_ctl_t ctl,
  input  fqd_pkg::handle_t   handle,
  input  fqd_pkg::handle_t   right_data,
  input  logic               found_in,
  output fqd_pkg::handle_t   data,
  output logic               found_out
);

  fqd_pkg::handle_t data_next;
  logic             hit;

  assign hit = ctl.live && ctl.del_en && (data == handle);

  // Once an older cell is removed (or this one matches), this cell takes its
  // younger neighbor's entry so the gap closes.
  assign found_out = found_in || hit;

  always_comb begin
    if (ctl.wr) begin
      data_next = handle;
    end else if (found_out) begin
      data_next = right_data;
    end else begin
      data_next = data;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data <= data_next;
    end
  end

endmodule

/* rtl/fqd_checker.sv */
// Port-level checks for fifo_queue_with_delete and the bind that attaches them.
// Depends on fqd_pkg and on the top level's ports.
module fqd_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_stall,
  input logic          out_valid,
  input logic          out_stall,
  input fqd_pkg::out_t out_item
);

  // A stalled result item stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

  // With the result register empty the block never refuses an item.
  a_take: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with no pending result");

  // An accepted item always yields a result in the next cycle.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item produced no result");

  // A failed request returns no handle, and the queue never overfills.
  a_res: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_item.status || out_item.out_handle == '0) &&
                  (out_item.fill_level <= fqd_pkg::cnt_t'(fqd_pkg::QUEUE_DEPTH)))
    else $error("inconsistent result item");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
